// ===== rtl/core/frame_rate_meter_limiter_top_assert.svh =====
// Assertion macros for the frame rate meter and limiter.
// Each macro expands to a labeled concurrent assertion in simulation and to nothing in synthesis.
`ifndef FRAME_RATE_METER_LIMITER_TOP_ASSERT_SVH
`define FRAME_RATE_METER_LIMITER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define FRML_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frml: same-cycle implication failed");
// The consequent must hold in the cycle after the antecedent.
`define FRML_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frml: next-cycle implication failed");
// The expression must never be true.
`define FRML_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("frml: forbidden condition seen");
`else
`define FRML_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FRML_ASSERT_NXT(lbl, clk, rst, ante, cons)
`define FRML_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== rtl/core/frml_pkg.sv =====
`default_nettype none

package frml_pkg;

  // Default averaging window and fixed field widths.
  localparam int unsigned FRML_WINDOW = 10;
  localparam int unsigned TS_W = 32;
  localparam int unsigned RATE_W = 10;

  // Arithmetic constants.
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned FPS_DEFAULT = 60;
  localparam int unsigned MAX_FPS_RESET = 60;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_UPDATE,
    OP_LOAD_AVG,
    OP_DIV_STEP,
    OP_LOAD_FPS,
    OP_SAVE_FPS,
    OP_LOAD_MF,
    OP_OUTPUT
  } op_t;

  // Jump conditions. A true condition jumps to the target, else the step counter advances.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_DIV_BUSY,
    C_AVG_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef logic [3:0] step_t;

  // Program step addresses.
  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_UPDATE   = 4'd1;
  localparam step_t ST_LOAD_AVG = 4'd2;
  localparam step_t ST_DIV_AVG  = 4'd3;
  localparam step_t ST_LOAD_FPS = 4'd4;
  localparam step_t ST_DIV_FPS  = 4'd5;
  localparam step_t ST_SAVE_FPS = 4'd6;
  localparam step_t ST_LOAD_MF  = 4'd7;
  localparam step_t ST_DIV_MF   = 4'd8;
  localparam step_t ST_FINISH   = 4'd9;
  localparam step_t ST_RETURN   = 4'd10;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Builds one control word.
  function automatic uword_t make_uword(op_t op, cond_t cond, step_t target);
    uword_t w;
    w.op = op;
    w.cond = cond;
    w.target = target;
    return w;
  endfunction

  // The control program, one word per step.
  function automatic uword_t ucode_rom(step_t pc);
    uword_t w;
    case (pc)
      ST_IDLE:     w = make_uword(OP_NOP,      C_NO_INPUT, ST_IDLE);
      ST_UPDATE:   w = make_uword(OP_UPDATE,   C_NEXT,     ST_IDLE);
      ST_LOAD_AVG: w = make_uword(OP_LOAD_AVG, C_NEXT,     ST_IDLE);
      ST_DIV_AVG:  w = make_uword(OP_DIV_STEP, C_DIV_BUSY, ST_DIV_AVG);
      ST_LOAD_FPS: w = make_uword(OP_LOAD_FPS, C_AVG_ZERO, ST_LOAD_MF);
      ST_DIV_FPS:  w = make_uword(OP_DIV_STEP, C_DIV_BUSY, ST_DIV_FPS);
      ST_SAVE_FPS: w = make_uword(OP_SAVE_FPS, C_NEXT,     ST_IDLE);
      ST_LOAD_MF:  w = make_uword(OP_LOAD_MF,  C_NEXT,     ST_IDLE);
      ST_DIV_MF:   w = make_uword(OP_DIV_STEP, C_DIV_BUSY, ST_DIV_MF);
      ST_FINISH:   w = make_uword(OP_OUTPUT,   C_OUT_BUSY, ST_FINISH);
      ST_RETURN:   w = make_uword(OP_NOP,      C_ALWAYS,   ST_IDLE);
      default:     w = make_uword(OP_NOP,      C_ALWAYS,   ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/frame_rate_meter_limiter_top.sv =====
// Frame rate meter and limiter.
// One request per frame arrives on the input channel (in_valid, in_stall) with the
// frame's start_ms and end_ms tick counts. One result leaves on the output channel
// (out_valid, out_stall) per request: the averaged frame rate fps over the last WINDOW
// frame-to-frame intervals, the delay_ms the frame would need to stay under max_fps,
// and interval_ms since the previous frame end. The block only reports the delay.
// The user must write max_fps through cfg_write and cfg_data while the block is idle;
// the block itself does not enforce this. A request is worked by a small control
// program driving one shared restoring divider that retires one quotient bit per
// cycle. The result is registered at the end of the program, and the next request
// is taken only once the program is back at idle. When the average interval is zero
// the first division of 1000 is skipped.
// The result sits in an output register; if the receiver stalls, the program holds
// at its output step until the previous result is taken, and in_stall stays high.
// Synchronous reset clears the previous end time, the ring position, fill count and
// sum, sets max_fps to 60, and takes the block to idle with no result pending.
`default_nettype none
`include "frame_rate_meter_limiter_top_assert.svh"

module frame_rate_meter_limiter_top
  import frml_pkg::*;
#(
  parameter int unsigned WINDOW = FRML_WINDOW
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [RATE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [TS_W-1:0]   start_ms,
  input  wire logic [TS_W-1:0]   end_ms,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [RATE_W-1:0]      fps,
  output logic [RATE_W-1:0]      delay_ms,
  output logic [TS_W-1:0]        interval_ms
);

  localparam int unsigned POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = TS_W + CNT_W;
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);

  // Sequencer.
  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   take;
  logic   in_acc;
  logic   out_busy;

  // Frame state and ring.
  logic [TS_W-1:0]  prev_end;
  logic [TS_W-1:0]  interval;
  logic [TS_W-1:0]  dur;
  logic [TS_W-1:0]  ring [WINDOW];
  logic [TS_W-1:0]  old_entry;
  logic [POS_W-1:0] ring_pos;
  logic [CNT_W-1:0] fill;
  logic [SUM_W-1:0] sum;
  logic             full;

  // Shared divider.
  logic [SUM_W-1:0]  div_rem;
  logic [SUM_W-1:0]  div_q;
  logic [SUM_W-1:0]  div_d;
  logic [DCNT_W-1:0] div_cnt;
  logic [SUM_W:0]    trial;
  logic              trial_ge;
  logic [SUM_W:0]    trial_diff;

  // Limiter.
  logic [RATE_W-1:0]   max_fps;
  logic [RATE_W-1:0]   mf;
  logic [RATE_W-1:0]   fps_r;
  logic [2*RATE_W-1:0] dur_prod;
  logic                lim_ok;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (pc != ST_IDLE);
  assign out_busy = out_valid && out_stall;
  assign full     = (fill == CNT_W'(WINDOW));
  assign uw       = ucode_rom(pc);

  // Jump decision for the current step.
  always_comb begin
    case (uw.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !in_acc;
      C_DIV_BUSY: take = (div_cnt > DCNT_W'(1));
      C_AVG_ZERO: take = (div_q == '0);
      C_OUT_BUSY: take = out_busy;
      default:    take = 1'b0;
    endcase
    pc_next = take ? uw.target : step_t'(pc + step_t'(1));
  end

  // One restoring division step: shift in the next dividend bit and try to subtract.
  assign trial      = {div_rem, div_q[SUM_W-1]};
  assign trial_ge   = (trial >= {1'b0, div_d});
  assign trial_diff = trial - {1'b0, div_d};

  // A zero ceiling counts as one frame per second.
  assign mf       = (max_fps == '0) ? RATE_W'(1) : max_fps;
  assign dur_prod = dur[RATE_W-1:0] * mf;

  // Control state: step counter, frame history, ring bookkeeping, frame rate ceiling, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= ST_IDLE;
      out_valid <= 1'b0;
      prev_end  <= '0;
      ring_pos  <= '0;
      fill      <= '0;
      sum       <= '0;
      max_fps   <= RATE_W'(MAX_FPS_RESET);
    end else begin
      pc <= pc_next;
      if (cfg_write) begin
        max_fps <= cfg_data;
      end
      if (in_acc) begin
        prev_end <= end_ms;
      end
      if (out_valid && !out_stall && (uw.op != OP_OUTPUT)) begin
        out_valid <= 1'b0;
      end
      case (uw.op)
        OP_UPDATE: begin
          if (full) begin
            sum <= sum - SUM_W'(old_entry) + SUM_W'(interval);
          end else begin
            sum  <= sum + SUM_W'(interval);
            fill <= fill + CNT_W'(1);
          end
          if (ring_pos == POS_W'(WINDOW - 1)) begin
            ring_pos <= '0;
          end else begin
            ring_pos <= ring_pos + POS_W'(1);
          end
        end
        OP_OUTPUT: begin
          if (!out_busy) begin
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Interval ring: read the entry about to be replaced at accept, write it on update.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      old_entry <= ring[ring_pos];
    end
    if (uw.op == OP_UPDATE) begin
      ring[ring_pos] <= interval;
    end
  end

  // Payload datapath: captured frame values, divider, limiter, output registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      interval <= end_ms - prev_end;
      dur      <= end_ms - start_ms;
    end
    case (uw.op)
      OP_LOAD_AVG: begin
        div_rem <= '0;
        div_q   <= sum;
        div_d   <= SUM_W'(fill);
        div_cnt <= DCNT_W'(SUM_W);
      end
      OP_DIV_STEP: begin
        div_rem <= trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
        div_q   <= {div_q[SUM_W-2:0], trial_ge};
        div_cnt <= div_cnt - DCNT_W'(1);
      end
      OP_LOAD_FPS: begin
        // The quotient register holds the average interval here.
        if (div_q == '0) begin
          fps_r <= RATE_W'(FPS_DEFAULT);
        end else begin
          div_rem <= '0;
          div_d   <= div_q;
          div_q   <= {RATE_W'(MS_PER_SEC), {(SUM_W - RATE_W){1'b0}}};
          div_cnt <= DCNT_W'(RATE_W);
        end
      end
      OP_SAVE_FPS: begin
        fps_r <= div_q[RATE_W-1:0];
      end
      OP_LOAD_MF: begin
        div_rem <= '0;
        div_d   <= SUM_W'(mf);
        div_q   <= {RATE_W'(MS_PER_SEC), {(SUM_W - RATE_W){1'b0}}};
        div_cnt <= DCNT_W'(RATE_W);
        lim_ok  <= (dur < TS_W'(MS_PER_SEC)) && (dur_prod < (2*RATE_W)'(MS_PER_SEC));
      end
      OP_OUTPUT: begin
        if (!out_busy) begin
          fps         <= fps_r;
          delay_ms    <= lim_ok ? (div_q[RATE_W-1:0] - dur[RATE_W-1:0]) : '0;
          interval_ms <= interval;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks on the sequencer and ring bookkeeping.
  `FRML_ASSERT_NEVER(a_fill_bound, clk, rst, fill > CNT_W'(WINDOW))
  `FRML_ASSERT_NEVER(a_pos_bound, clk, rst, 32'(ring_pos) >= WINDOW)
  `FRML_ASSERT_NXT(a_accept_update, clk, rst, in_acc, pc == ST_UPDATE)
  `FRML_ASSERT_IMP(a_out_from_finish, clk, rst, $rose(out_valid), $past(pc) == ST_FINISH)

endmodule

`default_nettype wire

// ===== dv/frml_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the frame rate meter, predicts each report from the
// frames it sees accepted and compares the reports that come out.
module frml_checker
  import frml_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [RATE_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [TS_W-1:0]   start_ms,
  input  logic [TS_W-1:0]   end_ms,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [RATE_W-1:0] fps,
  input  logic [RATE_W-1:0] delay_ms,
  input  logic [TS_W-1:0]   interval_ms,
  output int                mismatch_count,
  output int                results_checked,
  output int                reports_pending
);

  typedef struct packed {
    logic [RATE_W-1:0] fps;
    logic [RATE_W-1:0] delay;
    logic [TS_W-1:0]   interval;
  } frame_report_t;

  // Reports predicted for accepted frames, oldest first.
  frame_report_t reports_due[$];

  // Shadow of the meter state and the frame rate ceiling.
  logic [RATE_W-1:0] fps_ceiling;
  logic [TS_W-1:0]   last_end;
  logic [TS_W-1:0]   recent_gaps[FRML_WINDOW];
  int unsigned       gap_slot;
  int unsigned       gaps_held;
  logic [35:0]       gap_total;

  int errors = 0;
  int checked = 0;
  int pending = 0;

  assign mismatch_count = errors;
  assign results_checked = checked;
  assign reports_pending = pending;

  // Advances the shadow state by one frame and works out its report.
  task automatic predict_frame_report(input logic [TS_W-1:0] frame_start,
                                      input logic [TS_W-1:0] frame_end,
                                      output frame_report_t report);
    logic [TS_W-1:0]   gap;
    logic [35:0]       avg_gap;
    logic [TS_W-1:0]   duration;
    logic [RATE_W-1:0] ceiling;
    logic [41:0]       budget;
    gap = frame_end - last_end;
    last_end = frame_end;
    // Once the window is full, the oldest interval drops out of the sum.
    if (gaps_held >= FRML_WINDOW) begin
      gap_total -= recent_gaps[gap_slot];
    end else begin
      gaps_held++;
    end
    recent_gaps[gap_slot] = gap;
    gap_total += gap;
    gap_slot = (gap_slot + 1) % FRML_WINDOW;
    avg_gap = gap_total / gaps_held;
    report.fps = (avg_gap == 0) ? RATE_W'(FPS_DEFAULT) : RATE_W'(MS_PER_SEC / avg_gap);
    // A zero ceiling behaves as the lowest legal rate.
    duration = frame_end - frame_start;
    ceiling = (fps_ceiling == 0) ? RATE_W'(1) : fps_ceiling;
    budget = duration * ceiling;
    report.delay = (budget < MS_PER_SEC) ? RATE_W'(MS_PER_SEC / ceiling - duration) : '0;
    report.interval = gap;
  endtask

  always @(posedge clk) begin
    frame_report_t want;
    frame_report_t got;
    if (rst) begin
      fps_ceiling = RATE_W'(MAX_FPS_RESET);
      last_end = '0;
      gap_slot = 0;
      gaps_held = 0;
      gap_total = '0;
      reports_due.delete();
    end else begin
      // Predict the report of every accepted request.
      if (in_valid && !in_stall) begin
        predict_frame_report(start_ms, end_ms, want);
        reports_due.push_back(want);
      end
      if (cfg_write) begin
        fps_ceiling = cfg_data;
      end
      // Compare every accepted report with the oldest prediction.
      if (out_valid && !out_stall) begin
        got.fps = fps;
        got.delay = delay_ms;
        got.interval = interval_ms;
        if (reports_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: report with no frame waiting: fps %0d delay %0d interval %0h",
                     $realtime, got.fps, got.delay, got.interval);
          end
        end else begin
          want = reports_due.pop_front();
          checked++;
          if (got != want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: report differs: fps %0d/%0d delay %0d/%0d interval %0h/%0h",
                       $realtime, want.fps, got.fps, want.delay, got.delay,
                       want.interval, got.interval);
              $display("         (values are expected/actual)");
            end
          end
        end
      end
    end
    pending <= reports_due.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import frml_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [RATE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TS_W-1:0]   start_ms = '0;
  logic [TS_W-1:0]   end_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [RATE_W-1:0] fps;
  logic [RATE_W-1:0] delay_ms;
  logic [TS_W-1:0]   interval_ms;

  int mismatch_count;
  int results_checked;
  int reports_pending;

  // When set, neither side idles.
  bit steady = 1'b0;
  int frames_sent = 0;
  int ceilings_used = 0;
  logic [TS_W-1:0] clock_ms = '0;

  frame_rate_meter_limiter_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .start_ms(start_ms),
    .end_ms(end_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fps(fps),
    .delay_ms(delay_ms),
    .interval_ms(interval_ms)
  );

  frml_checker scoreboard (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .start_ms(start_ms),
    .end_ms(end_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fps(fps),
    .delay_ms(delay_ms),
    .interval_ms(interval_ms),
    .mismatch_count(mismatch_count),
    .results_checked(results_checked),
    .reports_pending(reports_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random unless the steady stretch is on.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 37);
    end
  end

  // Presents one frame request, after a random gap unless steady is set, and holds it until accepted.
  task automatic send_frame(input logic [TS_W-1:0] frame_start,
                            input logic [TS_W-1:0] frame_end);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 37) gap++;
      if ($urandom_range(0, 19) == 0) gap += $urandom_range(1, 70);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_ms <= frame_start;
    end_ms <= frame_end;
    do @(posedge clk); while (in_stall);
    frames_sent++;
  endtask

  // Makes one frame: mostly a plausible frame sequence, sometimes raw noise.
  task automatic random_frame();
    int pick;
    logic [TS_W-1:0] step;
    logic [TS_W-1:0] duration;
    logic [TS_W-1:0] frame_start;
    logic [TS_W-1:0] frame_end;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      frame_start = $urandom;
      frame_end = $urandom;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) step = $urandom_range(1, 40);
      else if (pick < 65) step = '0;
      else if (pick < 90) step = $urandom_range(41, 1500);
      else step = $urandom;
      duration = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 40) : $urandom_range(0, 1200);
      frame_end = clock_ms + step;
      frame_start = frame_end - duration;
    end
    clock_ms = frame_end;
    send_frame(frame_start, frame_end);
  endtask

  // Lets every outstanding report come back before going on.
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
  endtask

  task automatic set_fps_ceiling(input logic [RATE_W-1:0] ceiling);
    cfg_write <= 1'b1;
    cfg_data <= ceiling;
    @(posedge clk);
    cfg_write <= 1'b0;
    ceilings_used++;
  endtask

  initial begin
    int ceilings[6];
    ceilings = '{1, 1000, 0, 1023, 0, 30};
    ceilings[4] = $urandom_range(2, 999);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at the reset ceiling: zero intervals, wrapping
    // timestamps and durations, long averages, then a ring refill.
    send_frame(32'h0, 32'h0);
    send_frame(32'h0, 32'h0);
    send_frame(32'd0, 32'd15);
    send_frame(32'd15, 32'd31);
    send_frame(32'd31, 32'd48);
    send_frame(32'hFFFF_FFFF, 32'h0000_0005);
    send_frame(32'h0000_0010, 32'h0000_0005);
    send_frame(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(32'h0, 32'h0);
    for (int k = 1; k <= 5; k++) begin
      send_frame(k * 3000 - 1000, k * 3000);
    end
    for (int k = 1; k <= 10; k++) begin
      send_frame(15000 + k, 15000 + k);
    end
    drain_reports();

    // Random phases, each under its own ceiling, draining in between.
    for (int phase = 0; phase < 6; phase++) begin
      set_fps_ceiling(RATE_W'(ceilings[phase]));
      steady = (phase == 2);
      clock_ms = (phase % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
      for (int n = 0; n < 170; n++) begin
        random_frame();
      end
      drain_reports();
    end
    steady = 1'b0;

    // Give a stray report time to show up.
    repeat (80) @(posedge clk);

    $display("Sent %0d frames and checked %0d reports under %0d frame rate ceilings,",
             frames_sent, results_checked, ceilings_used + 1);
    $display("including a zero ceiling, ceilings above 1000 and wrapping timestamps.");
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("Timed out waiting for the block.");
    $display("Mismatches found");
    $finish;
  end

endmodule
